### hw/rtl/bpm_pkg.sv
// bpm_pkg: shared types, character codes and decode helpers for the bracket pair matcher.
// No dependencies; imported by bpm_stack, bpm_ctrl and bracket_pair_matcher_unit.
`default_nettype none

package bpm_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int CHAR_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int DEPTH_W  = 8;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        K_ROUND  = 2'd0,
        K_SQUARE = 2'd1,
        K_CURLY  = 2'd2,
        K_QUOTE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_SCAN     = 3'd0,
        ST_MATCH    = 3'd1,
        ST_NOTOPEN  = 3'd2,
        ST_WRONG    = 3'd3,
        ST_UNCLOSED = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_IDLE     = 3'd6
    } status_t;

    // stack operation for one beat
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  spill;   // old top moves down into the memory
        kind_t kind;
    } stack_op_t;

    typedef struct packed {
        status_t              status;
        logic [OFFSET_W-1:0]  offset;
        logic [DEPTH_W-1:0]   depth;
    } result_t;

    function automatic logic is_opener(input logic [CHAR_W-1:0] c);
        return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE) || (c == CH_QUOTE);
    endfunction

    function automatic kind_t opener_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        k = K_QUOTE;
        if (c == CH_LPAREN) k = K_ROUND;
        else if (c == CH_LBRACK) k = K_SQUARE;
        else if (c == CH_LBRACE) k = K_CURLY;
        return k;
    endfunction

    function automatic logic is_closer(input logic [CHAR_W-1:0] c);
        return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
    endfunction

    function automatic kind_t closer_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        k = K_CURLY;
        if (c == CH_RPAREN) k = K_ROUND;
        else if (c == CH_RBRACK) k = K_SQUARE;
        return k;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bpm_stack.sv
// bpm_stack: bracket stack with the top entry in a register and the rest in a memory.
// Depends on bpm_pkg; driven by bpm_ctrl, which owns the entry count.
`default_nettype none

module bpm_stack #(
    parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF,
    parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bpm_pkg::stack_op_t op,
    input  wire logic [CW-1:0]     count_cur,
    input  wire logic [CW-1:0]     count_nxt,
    output bpm_pkg::kind_t         top_kind
);
    import bpm_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    kind_t         mem [STACK_DEPTH];
    kind_t         top_reg;
    kind_t         rd_reg;
    kind_t         save_reg;
    logic          bypass_reg;
    kind_t         below;
    logic [CW-1:0] wr_cnt;
    logic [CW-1:0] rd_cnt;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // the old top is written just below the new top; read the entry under the next top
    assign wr_cnt  = count_cur - CW'(1);
    assign rd_cnt  = count_nxt - CW'(2);
    assign wr_addr = wr_cnt[AW-1:0];
    assign rd_addr = rd_cnt[AW-1:0];

    // a spill not yet visible through the memory read is taken from save_reg
    assign below    = bypass_reg ? save_reg : rd_reg;
    assign top_kind = top_reg;

    always_ff @(posedge aclk) begin
        if (op.spill) begin
            mem[wr_addr] <= top_reg;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (op.spill) begin
            save_reg <= top_reg;
        end
        if (op.push) begin
            top_reg <= op.kind;
        end else if (op.pop) begin
            top_reg <= below;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg <= 1'b0;
        end else begin
            bypass_reg <= op.spill;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bpm_ctrl.sv
// bpm_ctrl: scan state (active, escape, count, offset) and per-beat status decision.
// Depends on bpm_pkg; reads the stack top from bpm_stack.
`default_nettype none

module bpm_ctrl #(
    parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF,
    parameter int OFFSET_BITS = bpm_pkg::OFFSET_BITS_DEF,
    parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        beat,
    input  wire logic [bpm_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                        span_first,
    input  wire logic                        span_last,
    input  wire bpm_pkg::kind_t              top_kind,
    output bpm_pkg::stack_op_t               op,
    output logic [CW-1:0]                    count_cur,
    output logic [CW-1:0]                    count_nxt,
    output bpm_pkg::result_t                 res
);
    import bpm_pkg::*;

    logic                   active_reg, active_next;
    logic                   esc_reg, esc_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    logic [CW-1:0]          base_cnt;
    logic [CW-1:0]          cnt_after;
    logic                   base_esc;
    logic [OFFSET_BITS-1:0] offset_cur;
    logic                   top_quote;
    status_t                status;

    assign count_cur = count_reg;
    assign count_nxt = count_next;

    always_comb begin
        op          = '0;
        res.status  = ST_IDLE;
        res.offset  = '0;
        res.depth   = '0;
        active_next = active_reg;
        esc_next    = esc_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        base_cnt    = span_first ? '0 : count_reg;
        base_esc    = span_first ? 1'b0 : esc_reg;
        offset_cur  = span_first ? '0 : offset_reg;
        top_quote   = (base_cnt != '0) && (top_kind == K_QUOTE);
        cnt_after   = base_cnt;
        status      = ST_SCAN;

        if (beat && (span_first || active_reg)) begin
            offset_next = (&offset_cur) ? offset_cur : offset_cur + OFFSET_BITS'(1);
            active_next = 1'b1;
            esc_next    = base_esc;

            priority if (span_first && !(is_opener(char_code) &&
                                         opener_kind(char_code) != K_QUOTE)) begin
                status    = ST_NOTOPEN;
                cnt_after = '0;
            end else if (base_esc) begin
                esc_next = 1'b0;
            end else if (top_quote) begin
                if (char_code == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (char_code == CH_QUOTE) begin
                    op.pop    = 1'b1;
                    cnt_after = base_cnt - CW'(1);
                end
            end else if (is_opener(char_code)) begin
                if (base_cnt >= CW'(STACK_DEPTH)) begin
                    status    = ST_OVERFLOW;
                    cnt_after = CW'(STACK_DEPTH);
                end else begin
                    op.push   = 1'b1;
                    op.spill  = (base_cnt != '0);
                    op.kind   = opener_kind(char_code);
                    cnt_after = base_cnt + CW'(1);
                end
            end else if (is_closer(char_code)) begin
                if ((base_cnt != '0) && (top_kind == closer_kind(char_code))) begin
                    op.pop    = 1'b1;
                    cnt_after = base_cnt - CW'(1);
                end else begin
                    status    = ST_WRONG;
                    cnt_after = '0;
                end
            end

            // closing the outermost bracket wins over span end
            if (status == ST_SCAN) begin
                if (cnt_after == '0) begin
                    status = ST_MATCH;
                end else if (span_last) begin
                    status = ST_UNCLOSED;
                end
            end

            res.status = status;
            res.offset = OFFSET_W'(offset_cur);
            res.depth  = (32'(cnt_after) > 32'd255) ? 8'hFF : DEPTH_W'(cnt_after);

            if (status == ST_SCAN) begin
                count_next = cnt_after;
            end else begin
                count_next  = '0;
                active_next = 1'b0;
                esc_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
            offset_reg <= '0;
        end else begin
            active_reg <= active_next;
            esc_reg    <= esc_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

`ifndef SYNTH
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (count_reg == '0) && !esc_reg)
        else $error("idle scanner holds stack entries or escape");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_closed_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && (res.status == ST_MATCH || res.status == ST_NOTOPEN ||
                 res.status == ST_WRONG) |-> res.depth == '0)
        else $error("closing status with open entries");
`endif

endmodule

`default_nettype wire

### hw/rtl/bracket_pair_matcher_unit.sv
// bracket_pair_matcher_unit: top level; input beat decode, stack, and output register.
// Depends on bpm_pkg, bpm_ctrl and bpm_stack.
//
//  channel | direction | ports                                          | flow
//  s_      | in        | s_char_code, s_span_first, s_span_last         | s_valid / s_ready
//  m_      | out       | m_scan_status, m_match_offset, m_nest_depth    | m_valid / m_ready
//
// One character per cycle while m_ready keeps the output register drained; each accepted beat's result is registered.
// Stack push, pop and top compare finish in the accept cycle; the top sits in a
// register and the entry below is prefetched from the stack memory.
// s_ready is high whenever the output register is empty or being drained.
// Reset (aresetn low, synchronous) empties the stack and leaves the scanner idle.
`default_nettype none

module bracket_pair_matcher_unit #(
    parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF,
    parameter int OFFSET_BITS = bpm_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bpm_pkg::CHAR_W-1:0]    s_char_code,
    input  wire logic                          s_span_first,
    input  wire logic                          s_span_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_scan_status,
    output logic [bpm_pkg::OFFSET_W-1:0]       m_match_offset,
    output logic [bpm_pkg::DEPTH_W-1:0]        m_nest_depth
);
    import bpm_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic          beat;
    stack_op_t     op;
    kind_t         top_kind;
    logic [CW-1:0] count_cur;
    logic [CW-1:0] count_nxt;
    result_t       res;
    result_t       res_reg;
    logic          valid_reg;

    assign s_ready = !valid_reg || m_ready;
    assign beat    = s_valid && s_ready;

    bpm_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .OFFSET_BITS (OFFSET_BITS),
        .CW          (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (beat),
        .char_code  (s_char_code),
        .span_first (s_span_first),
        .span_last  (s_span_last),
        .top_kind   (top_kind),
        .op         (op),
        .count_cur  (count_cur),
        .count_nxt  (count_nxt),
        .res        (res)
    );

    bpm_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .CW          (CW)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .count_cur (count_cur),
        .count_nxt (count_nxt),
        .top_kind  (top_kind)
    );

    always_ff @(posedge aclk) begin
        if (beat) begin
            res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (beat) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_valid        = valid_reg;
    assign m_scan_status  = res_reg.status;
    assign m_match_offset = res_reg.offset;
    assign m_nest_depth   = res_reg.depth;

`ifndef SYNTH
    a_beat_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        beat |=> m_valid)
        else $error("accepted beat produced no result");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// testbench: self-checking bench for bracket_pair_matcher_unit with its own nesting predictor.
// Depends on bpm_pkg (status and kind enums, character codes) and the matcher RTL.
// Random bracket and string spans, plus directed cases, drive a valid/ready stream.
module testbench;
    import bpm_pkg::*;

    localparam int NEST_LIMIT = STACK_DEPTH_DEF;
    localparam int SPAN_ITEMS = 1800;
    localparam int HOLD_AT    = 400;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              span_first;
        logic              span_last;
        bit                wait_drain;
    } char_beat_t;

    typedef struct {
        status_t             status;
        logic [OFFSET_W-1:0] offset;
        logic [DEPTH_W-1:0]  depth;
    } scan_result_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CHAR_W-1:0] s_char_code = '0;
    logic s_span_first = 1'b0;
    logic s_span_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_scan_status;
    logic [OFFSET_W-1:0] m_match_offset;
    logic [DEPTH_W-1:0] m_nest_depth;

    bracket_pair_matcher_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_span_first   (s_span_first),
        .s_span_last    (s_span_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scan_status  (m_scan_status),
        .m_match_offset (m_match_offset),
        .m_nest_depth   (m_nest_depth)
    );

    char_beat_t   pending_chars[$];
    scan_result_t awaited_results[$];
    char_beat_t   beat_on_bus;
    bit           drain_next = 0;
    int           fail_count = 0;
    int unsigned  n_sent = 0;
    int unsigned  n_recv = 0;
    logic         quiet_tail = 1'b0;

    // predictor state
    kind_t               open_kinds[NEST_LIMIT];
    int unsigned         open_count = 0;
    bit                  in_escape = 0;
    logic [OFFSET_W-1:0] span_pos = '0;
    bit                  span_live = 0;

    // idling state of both sides
    int send_gap = 0;
    int send_odds = 4;
    int send_cycles = 0;
    int recv_stall = 0;
    int recv_odds = 4;
    int recv_cycles = 0;
    bit long_hold_done = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic scan_char(input char_beat_t b);
        scan_result_t r;
        kind_t k;
        bit is_open, is_close;
        r.status = ST_SCAN;
        r.offset = '0;
        r.depth  = '0;
        k = K_ROUND;
        is_open = 0;
        is_close = 0;
        if (b.span_first) begin
            open_count = 0;
            in_escape = 0;
            span_pos = '0;
            span_live = 1;
        end else if (!span_live) begin
            r.status = ST_IDLE;
            awaited_results.push_back(r);
            return;
        end
        r.offset = span_pos;
        if (span_pos != '1) span_pos = span_pos + 1'b1;
        case (b.code)
            CH_LPAREN: begin is_open = 1; k = K_ROUND; end
            CH_LBRACK: begin is_open = 1; k = K_SQUARE; end
            CH_LBRACE: begin is_open = 1; k = K_CURLY; end
            CH_QUOTE:  begin is_open = 1; k = K_QUOTE; end
            CH_RPAREN: begin is_close = 1; k = K_ROUND; end
            CH_RBRACK: begin is_close = 1; k = K_SQUARE; end
            CH_RBRACE: begin is_close = 1; k = K_CURLY; end
            default: ;
        endcase
        if (b.span_first && !(is_open && k != K_QUOTE)) begin
            span_live = 0;
            open_count = 0;
            in_escape = 0;
            r.status = ST_NOTOPEN;
            awaited_results.push_back(r);
            return;
        end
        if (in_escape) begin
            in_escape = 0;
        end else if (open_count > 0 && open_kinds[open_count-1] == K_QUOTE) begin
            if (b.code == CH_BSLASH) in_escape = 1;
            else if (b.code == CH_QUOTE) open_count--;
        end else if (is_open) begin
            if (open_count >= NEST_LIMIT) begin
                open_count = NEST_LIMIT;
                r.status = ST_OVERFLOW;
            end else begin
                open_kinds[open_count] = k;
                open_count++;
            end
        end else if (is_close) begin
            if (open_count > 0 && open_kinds[open_count-1] == k) begin
                open_count--;
            end else begin
                open_count = 0;
                r.status = ST_WRONG;
            end
        end
        if (r.status == ST_SCAN) begin
            if (open_count == 0) r.status = ST_MATCH;
            else if (b.span_last) r.status = ST_UNCLOSED;
        end
        r.depth = (open_count > 255) ? 8'd255 : DEPTH_W'(open_count);
        if (r.status != ST_SCAN) begin
            span_live = 0;
            open_count = 0;
            in_escape = 0;
        end
        awaited_results.push_back(r);
    endtask

    // driver: sender side of the input channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_char_code <= '0;
            s_span_first <= 1'b0;
            s_span_last <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_char(beat_on_bus);
                n_sent <= n_sent + 1;
            end
            if (!s_valid || s_ready) begin
                send_cycles++;
                if (send_cycles % 200 == 0) send_odds = $urandom_range(0, 6);
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_chars.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_chars[0].wait_drain &&
                             (n_sent != n_recv || (s_valid && s_ready))) begin
                    s_valid <= 1'b0;
                end else if (!quiet_tail && send_odds != 0 &&
                             $urandom_range(0, send_odds) == 0) begin
                    send_gap = $urandom_range(0, 2);
                    s_valid <= 1'b0;
                end else begin
                    beat_on_bus = pending_chars.pop_front();
                    s_valid <= 1'b1;
                    s_char_code <= beat_on_bus.code;
                    s_span_first <= beat_on_bus.span_first;
                    s_span_last <= beat_on_bus.span_last;
                end
            end
            quiet_tail <= (pending_chars.size() < 200);
        end
    end

    // receiver readiness, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            recv_cycles++;
            if (recv_cycles % 200 == 0) recv_odds = $urandom_range(0, 6);
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && n_recv >= HOLD_AT) begin
                long_hold_done = 1;
                recv_stall = 79;
                m_ready <= 1'b0;
            end else if (!quiet_tail && recv_odds != 0 &&
                         $urandom_range(0, recv_odds) == 0) begin
                recv_stall = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: result beats against the oldest prediction
    always @(posedge aclk) begin
        scan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_recv <= n_recv + 1;
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing predicted: status %0d offset %0d depth %0d",
                       m_scan_status, m_match_offset, m_nest_depth);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_scan_status !== want.status) begin
                    $error("scan_status: expected %0d, actual %0d", want.status, m_scan_status);
                    fail_count++;
                end
                if (m_match_offset !== want.offset) begin
                    $error("match_offset: expected %0d, actual %0d", want.offset,
                           m_match_offset);
                    fail_count++;
                end
                if (m_nest_depth !== want.depth) begin
                    $error("nest_depth: expected %0d, actual %0d", want.depth, m_nest_depth);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_char(input logic [CHAR_W-1:0] c, input logic f, input logic l);
        char_beat_t b;
        b.code = c;
        b.span_first = f;
        b.span_last = l;
        b.wait_drain = drain_next;
        drain_next = 0;
        pending_chars.push_back(b);
    endtask

    function automatic logic [CHAR_W-1:0] pick_opener();
        case ($urandom_range(0, 2))
            0: return CH_LPAREN;
            1: return CH_LBRACK;
            default: return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_closer();
        case ($urandom_range(0, 2))
            0: return CH_RPAREN;
            1: return CH_RBRACK;
            default: return CH_RBRACE;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] closer_for(input logic [CHAR_W-1:0] c);
        case (c)
            CH_LPAREN: return CH_RPAREN;
            CH_LBRACK: return CH_RBRACK;
            default: return CH_RBRACE;
        endcase
    endfunction

    // any byte that is neither a bracket nor a quote
    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom_range(0, 255));
        end while (c inside {CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                             CH_LBRACE, CH_RBRACE, CH_QUOTE});
        return c;
    endfunction

    // one mostly well-formed span with random content
    task automatic build_span(output int produced);
        logic [CHAR_W-1:0] body[$];
        logic [CHAR_W-1:0] closers[$];
        logic [CHAR_W-1:0] c;
        int steps, pick, last_at;
        if ($urandom_range(0, 14) == 0) c = CHAR_W'($urandom_range(0, 255));
        else c = pick_opener();
        body.push_back(c);
        if (c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE) closers.push_back(closer_for(c));
        // now and then a nest deep enough to come near or go past the stack limit
        if (closers.size() > 0 && $urandom_range(0, 39) == 0) begin
            repeat ($urandom_range(120, 132)) begin
                c = pick_opener();
                body.push_back(c);
                closers.push_back(closer_for(c));
            end
        end
        steps = $urandom_range(1, 24);
        for (int i = 0; i < steps && closers.size() > 0; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && closers.size() < 10) begin
                c = pick_opener();
                body.push_back(c);
                closers.push_back(closer_for(c));
            end else if (pick < 45 && closers.size() > 1) begin
                body.push_back(closers.pop_back());
            end else if (pick < 62) begin
                body.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            body.push_back(CH_BSLASH);
                            body.push_back(CHAR_W'($urandom_range(0, 255)));
                        end
                        1: body.push_back(pick_opener());
                        2: body.push_back(pick_closer());
                        default: body.push_back(plain_char());
                    endcase
                end
                // occasionally leave the string open
                if ($urandom_range(0, 9) != 0) body.push_back(CH_QUOTE);
            end else if (pick < 66) begin
                body.push_back(pick_closer());
            end else if (pick < 70) begin
                body.push_back(CHAR_W'($urandom_range(0, 255)));
            end else begin
                body.push_back(plain_char());
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            while (closers.size() > 0) body.push_back(closers.pop_back());
            last_at = $urandom_range(0, 1) ? body.size() - 1 : -1;
        end else if (pick < 9) begin
            last_at = $urandom_range(0, body.size() - 1);
        end else begin
            last_at = -1;
        end
        foreach (body[i]) queue_char(body[i], i == 0, i == last_at);
        produced = body.size();
    endtask

    initial begin
        int made, n;

        // directed cases
        queue_char(8'hA5, 1'b0, 1'b0);          // idle before any span
        queue_char(CH_LPAREN, 1'b1, 1'b1);      // open bracket on a one-char span
        queue_char(CH_LBRACK, 1'b1, 1'b0);
        queue_char(CH_RBRACK, 1'b0, 1'b0);
        queue_char(CH_LBRACE, 1'b1, 1'b0);      // escaped quote inside a string
        queue_char(CH_QUOTE, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b0);
        queue_char(CH_QUOTE, 1'b0, 1'b0);
        queue_char(CH_QUOTE, 1'b0, 1'b0);
        queue_char(CH_RBRACE, 1'b0, 1'b0);
        queue_char(CH_LPAREN, 1'b1, 1'b0);      // wrong pair
        queue_char(CH_RBRACK, 1'b0, 1'b0);
        queue_char(CH_QUOTE, 1'b1, 1'b0);       // first char not an opening bracket
        queue_char(8'hFF, 1'b1, 1'b1);
        queue_char(CH_RPAREN, 1'b1, 1'b0);
        queue_char(CH_LPAREN, 1'b1, 1'b0);      // restart in the middle of a scan
        queue_char(CH_LPAREN, 1'b0, 1'b0);
        queue_char(CH_LBRACE, 1'b1, 1'b0);
        queue_char(CH_RBRACE, 1'b0, 1'b1);      // match wins over span end
        queue_char(CH_LBRACK, 1'b1, 1'b0);      // escape pending at span end
        queue_char(CH_QUOTE, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b1);
        queue_char(8'h5A, 1'b0, 1'b0);

        // overflow, sent once the block has drained
        drain_next = 1;
        queue_char(CH_LBRACE, 1'b1, 1'b0);
        repeat (NEST_LIMIT) queue_char(pick_opener(), 1'b0, 1'b0);
        queue_char(CH_RBRACE, 1'b0, 1'b0);

        // random spans with noise between them
        drain_next = 1;
        made = 0;
        while (made < SPAN_ITEMS) begin
            build_span(n);
            made += n;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3))
                    queue_char(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (pending_chars.size() > 0 || s_valid || awaited_results.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_stack.sv
hw/rtl/bpm_ctrl.sv
hw/rtl/bracket_pair_matcher_unit.sv
test/testbench.sv
